// ----- rtl/rcr_pkg.sv -----
// ----------------------------------------------------------------------------
// rcr_pkg
// Types, constants and helpers shared by the radio channel receiver modules.
// ----------------------------------------------------------------------------
package rcr_pkg;

  localparam int unsigned FILL_W      = 5;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned PPM_SLOTS   = 8;
  localparam int unsigned SUM_W       = 19;

  localparam logic [4:0]  SYNC_SLOT      = 5'd16;
  localparam logic [15:0] RESET_NEUTRAL  = 16'd1500;
  localparam logic [15:0] RESET_THROTTLE = 16'd1000;
  localparam logic [15:0] RESET_FAILSAFE = 16'd2000;
  localparam logic [15:0] RESET_FRAME    = 16'd20000;
  localparam logic [6:0]  RESET_REFRESH  = 7'd10;
  localparam logic [3:0]  RESET_NUM_CH   = 4'd8;

  typedef enum logic [2:0] {
    CFG_NUM_CHANNELS   = 3'd0,
    CFG_FAILSAFE_TICKS = 3'd1,
    CFG_REFRESH_TICKS  = 3'd2,
    CFG_FRAME_PERIOD   = 3'd3,
    CFG_NEUTRAL        = 3'd4,
    CFG_THROTTLE_SAFE  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [3:0]  num_channels;
    logic [15:0] failsafe_ticks;
    logic [6:0]  refresh_ticks;
    logic [15:0] frame_period_us;
    logic [15:0] neutral_us;
    logic [15:0] throttle_safe_us;
  } cfg_t;

  typedef enum logic {
    CMD_FINISH = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [FILL_W-1:0]   fill;
    logic                apply_loss;
    logic                emit;
    logic                lost;
  } cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } back_st_e;

  function automatic logic [FILL_W-1:0] stored_channels(logic [3:0] nc,
                                                        logic [FILL_W-1:0] limit);
    logic [FILL_W-1:0] n;
    n = {1'b0, nc};
    return (n < limit) ? n : limit;
  endfunction

endpackage

// ----- rtl/rcr_front.sv -----
// ----------------------------------------------------------------------------
// rcr_front
// Accepts packet bytes and ticks, parses packets and tracks timing.
// ----------------------------------------------------------------------------
module rcr_front import rcr_pkg::*; #(
  parameter int unsigned CHANNELS     = 16,
  parameter int unsigned PACKET_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        in_tick_i,
  input  logic [7:0]  in_byte_i,
  output logic        push_o,
  output cmd_t        cmd_o,
  input  logic        full_i,
  input  logic        release_i,
  output logic [15:0] staged_o [CHANNELS]
);

  localparam int unsigned PW = $clog2(PACKET_BYTES);
  localparam int unsigned IW = $clog2(CHANNELS);
  localparam logic [PW-1:0] LAST_POS = PW'(PACKET_BYTES - 1);

  logic [PW-1:0]     pos_q, pos_d;
  logic              prev_q, prev_d;
  logic              marker_q, marker_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [7:0]        hold_q, hold_d;
  logic              pend_q, pend_d;
  logic [31:0]       now_q, now_d;
  logic [31:0]       last_pkt_q, last_pkt_d;
  logic [6:0]        refresh_q, refresh_d;
  logic              lost_q, lost_d;
  logic              busy_q, busy_d;
  logic [15:0]       staged_q [CHANNELS];

  logic              fire, pos0, is_last;
  logic              marker_e, prev_e, pend_e;
  logic [FILL_W-1:0] fill_e, stored;
  logic [7:0]        bound_sum;
  logic [31:0]       now_inc, age;
  logic              lost_hit, emit;
  logic [6:0]        refresh_inc;
  logic              stg_we;

  assign pos0    = (pos_q == '0);
  assign is_last = (pos_q == LAST_POS);
  assign stored  = stored_channels(cfg_i.num_channels, FILL_W'(CHANNELS));

  assign in_ready_o = in_tick_i ? !full_i
                                : (!(pos0 && busy_q) && !(is_last && full_i));
  assign fire = in_valid_i && in_ready_o;

  assign marker_e  = pos0 ? 1'b0 : marker_q;
  assign prev_e    = pos0 ? 1'b0 : prev_q;
  assign pend_e    = pos0 ? 1'b0 : pend_q;
  assign fill_e    = pos0 ? '0 : fill_q;
  assign bound_sum = 8'(pos_q) + 8'({cfg_i.num_channels, 1'b0});

  assign now_inc     = now_q + 32'd1;
  assign age         = now_inc - last_pkt_q;
  assign lost_hit    = age > {16'd0, cfg_i.failsafe_ticks};
  assign refresh_inc = refresh_q + 7'd1;
  assign emit        = (cfg_i.refresh_ticks == '0) || (refresh_inc >= cfg_i.refresh_ticks);

  always_comb begin
    pos_d      = pos_q;
    prev_d     = prev_q;
    marker_d   = marker_q;
    fill_d     = fill_q;
    hold_d     = hold_q;
    pend_d     = pend_q;
    now_d      = now_q;
    last_pkt_d = last_pkt_q;
    refresh_d  = refresh_q;
    lost_d     = lost_q;
    busy_d     = busy_q;
    stg_we     = 1'b0;
    push_o     = 1'b0;
    cmd_o      = '0;
    if (fire) begin
      if (in_tick_i) begin
        now_d     = now_inc;
        lost_d    = lost_q | lost_hit;
        refresh_d = emit ? '0 : refresh_inc;
        if (lost_hit || emit) begin
          push_o           = 1'b1;
          cmd_o.kind       = CMD_TICK;
          cmd_o.apply_loss = lost_hit;
          cmd_o.emit       = emit;
          cmd_o.lost       = lost_q | lost_hit;
        end
      end else begin
        marker_d = marker_e;
        prev_d   = prev_e;
        fill_d   = fill_e;
        pend_d   = pend_e;
        if (marker_e) begin
          if (fill_e < stored) begin
            if (!pend_e) begin
              hold_d = in_byte_i;
              pend_d = 1'b1;
            end else begin
              stg_we = 1'b1;
              fill_d = fill_e + FILL_W'(1);
              pend_d = 1'b0;
            end
          end
        end else begin
          if (prev_e && (in_byte_i == 8'h00) && !pos0 &&
              (bound_sum <= 8'(PACKET_BYTES))) begin
            marker_d = 1'b1;
          end
          prev_d = (in_byte_i == 8'h00);
        end
        if (is_last) begin
          pos_d      = '0;
          last_pkt_d = now_q;
          lost_d     = 1'b0;
          busy_d     = 1'b1;
          push_o     = 1'b1;
          cmd_o.kind = CMD_FINISH;
          cmd_o.fill = fill_d;
        end else begin
          pos_d = pos_q + PW'(1);
        end
      end
    end
    if (release_i) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      prev_q     <= 1'b0;
      marker_q   <= 1'b0;
      fill_q     <= '0;
      hold_q     <= '0;
      pend_q     <= 1'b0;
      now_q      <= '0;
      last_pkt_q <= '0;
      refresh_q  <= '0;
      lost_q     <= 1'b0;
      busy_q     <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      prev_q     <= prev_d;
      marker_q   <= marker_d;
      fill_q     <= fill_d;
      hold_q     <= hold_d;
      pend_q     <= pend_d;
      now_q      <= now_d;
      last_pkt_q <= last_pkt_d;
      refresh_q  <= refresh_d;
      lost_q     <= lost_d;
      busy_q     <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_we) begin
      staged_q[fill_e[IW-1:0]] <= {hold_q, in_byte_i};
    end
  end

  assign staged_o = staged_q;

endmodule

// ----- rtl/rcr_queue.sv -----
// ----------------------------------------------------------------------------
// rcr_queue
// Short command queue between the packet front end and the output back end.
// ----------------------------------------------------------------------------
module rcr_queue import rcr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic empty_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + QPTR_W'(1) : wr_q;
    rd_d  = do_pop ? rd_q + QPTR_W'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (QPTR_W + 1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

// ----- rtl/rcr_back.sv -----
// ----------------------------------------------------------------------------
// rcr_back
// Holds the channel widths, applies packets and loss, and emits refresh runs.
// ----------------------------------------------------------------------------
module rcr_back import rcr_pkg::*; #(
  parameter int unsigned CHANNELS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  cmd_t        cmd_i,
  input  logic        empty_i,
  output logic        pop_o,
  output logic        release_o,
  input  logic [15:0] staged_i [CHANNELS],
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  out_slot_o,
  output logic [15:0] out_pulse_o,
  output logic        out_sync_o,
  output logic        out_lost_o,
  output logic        out_last_o
);

  localparam int unsigned IW = $clog2(CHANNELS);

  back_st_e          state_q, state_d;
  logic [15:0]       cw_q [CHANNELS];
  logic [15:0]       cw_d [CHANNELS];
  logic [4:0]        slot_q, slot_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic              run_lost_q, run_lost_d;
  logic              ov_q, ov_d;
  logic [4:0]        os_q, os_d;
  logic [15:0]       op_q, op_d;
  logic              osync_q, osync_d, olost_q, olost_d, olast_q, olast_d;
  logic [FILL_W-1:0] stored;
  logic              fire, load;
  logic [15:0]       cur_w, sync_w;

  assign stored = stored_channels(cfg_i.num_channels, FILL_W'(CHANNELS));
  assign fire   = ov_q && out_ready_i;
  assign load   = !ov_q || out_ready_i;
  assign cur_w  = cw_q[slot_q[IW-1:0]];
  assign sync_w = ({3'd0, cfg_i.frame_period_us} > sum_q)
                ? 16'({3'd0, cfg_i.frame_period_us} - sum_q) : 16'd0;

  always_comb begin
    state_d    = state_q;
    cw_d       = cw_q;
    slot_d     = slot_q;
    sum_d      = sum_q;
    run_lost_d = run_lost_q;
    ov_d       = fire ? 1'b0 : ov_q;
    os_d       = os_q;
    op_d       = op_q;
    osync_d    = osync_q;
    olost_d    = olost_q;
    olast_d    = olast_q;
    pop_o      = 1'b0;
    release_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (cmd_i.kind == CMD_FINISH) begin
            release_o = 1'b1;
            for (int ch = 0; ch < CHANNELS; ch++) begin
              if ((FILL_W'(ch) < cmd_i.fill) && (staged_i[ch] != 16'd0)) begin
                cw_d[ch] = staged_i[ch];
              end
              if (FILL_W'(ch) >= stored) begin
                cw_d[ch] = cfg_i.neutral_us;
              end
            end
          end else begin
            if (cmd_i.apply_loss) begin
              cw_d[0] = cfg_i.neutral_us;
              cw_d[1] = cfg_i.neutral_us;
              cw_d[2] = cfg_i.throttle_safe_us;
              cw_d[3] = cfg_i.neutral_us;
            end
            if (cmd_i.emit) begin
              state_d    = ST_RUN;
              slot_d     = '0;
              sum_d      = '0;
              run_lost_d = cmd_i.lost;
            end
          end
        end
      end
      ST_RUN: begin
        if (load) begin
          ov_d    = 1'b1;
          olost_d = run_lost_q;
          if (slot_q < 5'(CHANNELS)) begin
            os_d    = slot_q;
            op_d    = cur_w;
            osync_d = 1'b0;
            olast_d = 1'b0;
            if (slot_q < 5'(PPM_SLOTS)) begin
              sum_d = sum_q + SUM_W'(cur_w);
            end
            slot_d = slot_q + 5'd1;
          end else begin
            os_d    = SYNC_SLOT;
            op_d    = sync_w;
            osync_d = 1'b1;
            olast_d = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        cw_q[ch] <= (ch == 2) ? RESET_THROTTLE : RESET_NEUTRAL;
      end
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      cw_q    <= cw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q     <= slot_d;
    sum_q      <= sum_d;
    run_lost_q <= run_lost_d;
    os_q       <= os_d;
    op_q       <= op_d;
    osync_q    <= osync_d;
    olost_q    <= olost_d;
    olast_q    <= olast_d;
  end

  assign out_valid_o = ov_q;
  assign out_slot_o  = os_q;
  assign out_pulse_o = op_q;
  assign out_sync_o  = osync_q;
  assign out_lost_o  = olost_q;
  assign out_last_o  = olast_q;

  a_sync_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && osync_q) |-> (olast_q && (os_q == SYNC_SLOT)))
    else $error("sync slot does not end the run");

  a_no_pop_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> !pop_o)
    else $error("command taken while a run is emitted");

  a_mid_run_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !olast_q) |-> (state_q == ST_RUN))
    else $error("channel word delivered outside a run");

endmodule

// ----- rtl/rc_channel_receiver_failsafe.sv -----
// ----------------------------------------------------------------------------
// rc_channel_receiver_failsafe
// Radio channel receiver with failsafe handling and PPM refresh runs.
// ----------------------------------------------------------------------------
// The input stream carries one word per packet byte or millisecond tick; tuser
// selects the tick. Bytes are parsed at one per cycle while the input is not
// stalled. A tick that falls on a refresh period starts a run of CHANNELS
// channel words and a sync word on the output stream; tlast marks the sync
// word. A tick's command passes through the command queue before its run
// starts, and the output register loads one slot per cycle while the output
// is not stalled. Ticks arriving during a run wait in a four-entry command
// queue; the input stalls only when that queue is full or when a new packet
// starts before the previous one has been applied to the channel widths. A
// stalled output holds its word and the run pauses.
// Reset sets all channels to the neutral width with channel 2 at the throttle
// safe width, restores the register defaults and needs no clearing pass.
// ----------------------------------------------------------------------------
module rc_channel_receiver_failsafe import rcr_pkg::*; #(
  parameter int unsigned CHANNELS     = 16,
  parameter int unsigned PACKET_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] packet_byte
  input  logic        s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [4:0] slot_index, [20:5] pulse_us,
                                      // [21] loss_flag, [23:22] zero
  output logic        m_axis_tuser,   // [0] is_sync
  output logic        m_axis_tlast
);

  cfg_t        cfg_q;
  logic        push, full, pop, empty, release_pkt;
  cmd_t        cmd_in, cmd_out;
  logic [15:0] staged [CHANNELS];
  logic [4:0]  slot;
  logic [15:0] pulse;
  logic        lost;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_channels     <= RESET_NUM_CH;
      cfg_q.failsafe_ticks   <= RESET_FAILSAFE;
      cfg_q.refresh_ticks    <= RESET_REFRESH;
      cfg_q.frame_period_us  <= RESET_FRAME;
      cfg_q.neutral_us       <= RESET_NEUTRAL;
      cfg_q.throttle_safe_us <= RESET_THROTTLE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NUM_CHANNELS:   cfg_q.num_channels     <= cfg_wdata_i[3:0];
        CFG_FAILSAFE_TICKS: cfg_q.failsafe_ticks   <= cfg_wdata_i;
        CFG_REFRESH_TICKS:  cfg_q.refresh_ticks    <= cfg_wdata_i[6:0];
        CFG_FRAME_PERIOD:   cfg_q.frame_period_us  <= cfg_wdata_i;
        CFG_NEUTRAL:        cfg_q.neutral_us       <= cfg_wdata_i;
        CFG_THROTTLE_SAFE:  cfg_q.throttle_safe_us <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  rcr_front #(
    .CHANNELS     (CHANNELS),
    .PACKET_BYTES (PACKET_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_tick_i  (s_axis_tuser),
    .in_byte_i  (s_axis_tdata),
    .push_o     (push),
    .cmd_o      (cmd_in),
    .full_i     (full),
    .release_i  (release_pkt),
    .staged_o   (staged)
  );

  rcr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (cmd_out),
    .empty_o (empty)
  );

  rcr_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd_out),
    .empty_i     (empty),
    .pop_o       (pop),
    .release_o   (release_pkt),
    .staged_i    (staged),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_slot_o  (slot),
    .out_pulse_o (pulse),
    .out_sync_o  (m_axis_tuser),
    .out_lost_o  (lost),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, lost, pulse, slot};

endmodule
